### sv/assert_macros.svh
// Assertion macros for the checker file of the coordinate converter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a clock and a disable condition.
`define SPCC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication under a clock and a disable condition.
`define SPCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### sv/spcc_pkg.sv
// Shared types, constants and helper functions of the coordinate converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package spcc_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int ANGLE_BITS_DEFAULT    = 16;
   localparam int GUARD_BITS            = 8;
   // datapath width: Q12.4 plus guard bits plus CORDIC growth and sign
   localparam int CW = 28;
   // rounded coordinate width after guard removal, and one bit more for center adds
   localparam int RW = CW - GUARD_BITS;
   localparam int SW = RW + 1;

   // 1/K of the CORDIC in Q0.32
   localparam logic [31:0] INV_GAIN = 32'd2608131496;

   localparam logic [1:0] MODE_SCR2POL  = 2'd0;
   localparam logic [1:0] MODE_POL2SCR  = 2'd1;
   localparam logic [1:0] MODE_CART2POL = 2'd2;
   localparam logic [1:0] MODE_POL2CART = 2'd3;

   localparam logic [1:0] CSR_CENTER_X     = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y     = 2'd1;
   localparam logic [1:0] CSR_NORTH_OFFSET = 2'd2;

   localparam logic [15:0] NORTH_OFFSET_RESET = 16'd16384;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TAB [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic [15:0]        angle_in;
      logic [15:0]        radius_in;
   } spcc_req_type;

   typedef struct packed {
      logic [15:0]        angle_out;
      logic [15:0]        radius_out;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic               saturated;
   } spcc_rsp_type;

   // sideband that travels with each request through the pipeline
   typedef struct packed {
      logic [1:0] mode;
      logic       flip;
      logic       zero;
   } spcc_side_type;

   function automatic logic is_to_polar(input logic [1:0] mode);
      return (mode == MODE_SCR2POL) || (mode == MODE_CART2POL);
   endfunction

   // arctangent step rounded to the angle accumulator width
   function automatic logic [31:0] atan_at(input int idx, input int abits);
      logic [32:0] t;
      int          s;
      s = 32 - abits;
      t = {1'b0, ATAN_TAB[idx]} + (33'd1 << (s - 1));
      return 32'(t >> s);
   endfunction

   // clip to signed 16 bits; top bit of the result flags a clip
   function automatic logic [16:0] clip16(input logic signed [SW-1:0] v);
      logic [16:0] r;
      if (v > SW'(32767)) begin
         r = {1'b1, 16'h7FFF};
      end else if (v < SW'(-32768)) begin
         r = {1'b1, 16'h8000};
      end else begin
         r = {1'b0, v[15:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/spcc_pre.sv
// Front end of the converter: screen offset, half-plane fold and radius prescale.
// Depends on spcc_pkg.
`default_nettype none

module spcc_pre
   import spcc_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire spcc_req_type             in_data,
   input  wire logic signed [15:0]       center_x,
   input  wire logic signed [15:0]       center_y,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic signed [CW-1:0]          x_o,
   output logic signed [CW-1:0]          y_o,
   output logic        [ANGLE_BITS:0]    z_o,
   output spcc_side_type                 side_o
);

   localparam int AW = ANGLE_BITS + 1;
   localparam logic signed [AW-1:0] HALF    = AW'(1 << (ANGLE_BITS - 1));
   localparam logic signed [AW-1:0] QUARTER = AW'(1 << (ANGLE_BITS - 2));
   localparam int PW = 48;
   localparam logic [PW-1:0] PRE_RND = PW'(1) << 23;

   logic                  a_v_ff, b_v_ff;
   logic                  a_en, b_en;
   logic signed [CW-1:0]  a_x_in, a_y_in, a_x_ff, a_y_ff;
   logic [AW-1:0]         a_z_in, a_z_ff;
   logic [PW-1:0]         a_p_in, a_p_ff;
   spcc_side_type         a_side_in, a_side_ff;
   logic signed [CW-1:0]  b_x_in, b_x_ff, b_y_ff;
   logic [AW-1:0]         b_z_ff;
   spcc_side_type         b_side_ff;

   logic signed [16:0]    dx, dy, fx, fy;
   logic [39:0]           ang_ext;
   logic signed [AW-1:0]  zs;
   logic [PW-1:0]         p_rnd;

   assign b_en     = !b_v_ff || out_ready;
   assign a_en     = !a_v_ff || b_en;
   assign in_ready = a_en;

   // stage A: offset and fold for vectoring, angle fold and gain prescale for rotation
   always_comb begin
      if (in_data.req_type == MODE_SCR2POL) begin
         dx = {in_data.coord_x[15], in_data.coord_x} - {center_x[15], center_x};
         dy = {center_y[15], center_y} - {in_data.coord_y[15], in_data.coord_y};
      end else begin
         dx = {in_data.coord_x[15], in_data.coord_x};
         dy = {in_data.coord_y[15], in_data.coord_y};
      end
      fx = dx[16] ? -dx : dx;
      fy = dx[16] ? -dy : dy;

      ang_ext = {in_data.angle_in, 24'd0};
      zs      = {ang_ext[39], ang_ext[39 -: ANGLE_BITS]};

      a_side_in.mode = in_data.req_type;
      a_side_in.zero = (dx == '0) && (dy == '0);
      a_side_in.flip = 1'b0;
      a_p_in         = PW'(in_data.radius_in) * PW'(INV_GAIN);

      if (is_to_polar(in_data.req_type)) begin
         a_x_in = {{(CW - 17 - GUARD_BITS){fx[16]}}, fx, {GUARD_BITS{1'b0}}};
         a_y_in = {{(CW - 17 - GUARD_BITS){fy[16]}}, fy, {GUARD_BITS{1'b0}}};
         a_z_in = dx[16] ? HALF : '0;
      end else begin
         a_x_in = '0;
         a_y_in = '0;
         // fold into the right half-plane, flip the result later
         if (zs > QUARTER) begin
            a_z_in         = zs - HALF;
            a_side_in.flip = 1'b1;
         end else if (zs < -QUARTER) begin
            a_z_in         = zs + HALF;
            a_side_in.flip = 1'b1;
         end else begin
            a_z_in = zs;
         end
      end
   end

   // stage B: round the prescaled radius into the start vector
   always_comb begin
      p_rnd  = a_p_ff + PRE_RND;
      b_x_in = is_to_polar(a_side_ff.mode) ? a_x_ff
                                           : {{(CW - 24){1'b0}}, p_rnd[47:24]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (a_en) begin
            a_v_ff <= in_valid;
         end
         if (b_en) begin
            b_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_x_ff    <= a_x_in;
         a_y_ff    <= a_y_in;
         a_z_ff    <= a_z_in;
         a_p_ff    <= a_p_in;
         a_side_ff <= a_side_in;
      end
      if (b_en) begin
         b_x_ff    <= b_x_in;
         b_y_ff    <= a_y_ff;
         b_z_ff    <= a_z_ff;
         b_side_ff <= a_side_ff;
      end
   end

   assign out_valid = b_v_ff;
   assign x_o       = b_x_ff;
   assign y_o       = b_y_ff;
   assign z_o       = b_z_ff;
   assign side_o    = b_side_ff;

endmodule

`default_nettype wire

### sv/spcc_cordic.sv
// Unrolled CORDIC, one register stage per iteration, vectoring or rotation per request.
// Depends on spcc_pkg.
`default_nettype none

module spcc_cordic
   import spcc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT,
   parameter int ANGLE_BITS    = ANGLE_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [CW-1:0]     x_i,
   input  wire logic signed [CW-1:0]     y_i,
   input  wire logic        [ANGLE_BITS:0] z_i,
   input  wire spcc_side_type            side_i,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic signed [CW-1:0]          x_o,
   output logic signed [CW-1:0]          y_o,
   output logic        [ANGLE_BITS:0]    z_o,
   output spcc_side_type                 side_o
);

   localparam int AW = ANGLE_BITS + 1;

   logic [CORDIC_STAGES-1:0] v_ff;
   logic [CORDIC_STAGES:0]   en;
   logic signed [CW-1:0]     x_ff [CORDIC_STAGES];
   logic signed [CW-1:0]     y_ff [CORDIC_STAGES];
   logic [AW-1:0]            z_ff [CORDIC_STAGES];
   spcc_side_type            side_ff [CORDIC_STAGES];

   assign en[CORDIC_STAGES] = out_ready;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic [AW-1:0] STEP = AW'(atan_at(i, ANGLE_BITS));

      logic signed [CW-1:0] x_src, y_src, x_in, y_in, xs, ys;
      logic [AW-1:0]        z_src, z_in;
      spcc_side_type        side_src;
      logic                 v_src, dir;

      if (i == 0) begin : g_first
         assign x_src    = x_i;
         assign y_src    = y_i;
         assign z_src    = z_i;
         assign side_src = side_i;
         assign v_src    = in_valid;
      end else begin : g_next
         assign x_src    = x_ff[i-1];
         assign y_src    = y_ff[i-1];
         assign z_src    = z_ff[i-1];
         assign side_src = side_ff[i-1];
         assign v_src    = v_ff[i-1];
      end

      assign en[i] = !v_ff[i] || en[i+1];

      // vectoring drives y toward zero, rotation drives the residual angle toward zero
      always_comb begin
         xs  = x_src >>> i;
         ys  = y_src >>> i;
         dir = is_to_polar(side_src.mode) ? (!y_src[CW-1] && (y_src != '0))
                                          : z_src[AW-1];
         if (dir) begin
            x_in = x_src + ys;
            y_in = y_src - xs;
            z_in = z_src + STEP;
         end else begin
            x_in = x_src - ys;
            y_in = y_src + xs;
            z_in = z_src - STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en[i]) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_src;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[CORDIC_STAGES-1];
   assign x_o       = x_ff[CORDIC_STAGES-1];
   assign y_o       = y_ff[CORDIC_STAGES-1];
   assign z_o       = z_ff[CORDIC_STAGES-1];
   assign side_o    = side_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

### sv/spcc_post.sv
// Back end of the converter: gain removal, rounding, bearing offset, center add,
// saturation and the output register. Depends on spcc_pkg.
`default_nettype none

module spcc_post
   import spcc_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [CW-1:0]     x_i,
   input  wire logic signed [CW-1:0]     y_i,
   input  wire logic        [ANGLE_BITS:0] z_i,
   input  wire spcc_side_type            side_i,
   input  wire logic signed [15:0]       center_x,
   input  wire logic signed [15:0]       center_y,
   input  wire logic [15:0]              north_offset,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output spcc_rsp_type                  rsp_data
);

   localparam int PW = CW + 31;
   localparam logic [PW:0] MAG_RND = (PW + 1)'(1) << (32 + GUARD_BITS - 1);
   localparam logic signed [CW-1:0] GUARD_RND = CW'(1) << (GUARD_BITS - 1);
   localparam int ZW = ANGLE_BITS + 16;
   localparam logic [ZW-1:0] ANG_RND = ZW'(1) << (ANGLE_BITS - 1);

   logic                   v1_ff, v2_ff, v3_ff;
   logic                   e1, e2, e3;

   logic [PW-1:0]          q1_p_in, q1_p_ff;
   logic signed [CW-1:0]   q1_x_in, q1_y_in, q1_x_ff, q1_y_ff;
   logic [ANGLE_BITS-1:0]  q1_z_ff;
   spcc_side_type          q1_side_ff;
   logic [CW-2:0]          xc;

   logic [PW:0]            psum;
   logic [RW-1:0]          mag;
   logic [ZW-1:0]          zsum;
   logic signed [CW-1:0]   xr, yr;
   logic [15:0]            q2_ang_in, q2_ang_ff, q2_rad_in, q2_rad_ff;
   logic                   q2_flag_in, q2_flag_ff;
   logic signed [RW-1:0]   q2_cv_ff, q2_sv_ff;
   spcc_side_type          q2_side_ff;

   logic signed [SW-1:0]   ox_w, oy_w;
   logic [16:0]            ox_c, oy_c;
   spcc_rsp_type           rsp_in, rsp_ff;

   assign e3       = !v3_ff || rsp_ready;
   assign e2       = !v2_ff || e3;
   assign e1       = !v1_ff || e2;
   assign in_ready = e1;

   // Q1: remove the gain from the magnitude, undo the half-plane fold
   always_comb begin
      xc      = x_i[CW-1] ? '0 : x_i[CW-2:0];
      q1_p_in = PW'(xc) * PW'(INV_GAIN);
      q1_x_in = side_i.flip ? -x_i : x_i;
      q1_y_in = side_i.flip ? -y_i : y_i;
   end

   // Q2: round magnitude and coordinates, turn the angle into a bearing
   always_comb begin
      psum = {1'b0, q1_p_ff} + MAG_RND;
      mag  = psum[PW:32+GUARD_BITS];
      zsum = {q1_z_ff, 16'd0} + ANG_RND;
      xr   = q1_x_ff + GUARD_RND;
      yr   = q1_y_ff + GUARD_RND;
      if (q1_side_ff.zero) begin
         q2_ang_in  = north_offset;
         q2_rad_in  = '0;
         q2_flag_in = 1'b0;
      end else begin
         q2_ang_in  = north_offset - zsum[ZW-1 -: 16];
         q2_flag_in = (mag[RW-1:16] != '0);
         q2_rad_in  = q2_flag_in ? 16'hFFFF : mag[15:0];
      end
   end

   // Q3: screen offset for polar to screen, clipping for the modes that leave polar, field select
   always_comb begin
      if (q2_side_ff.mode == MODE_POL2SCR) begin
         ox_w = {q2_sv_ff[RW-1], q2_sv_ff} + {{(SW - 16){center_x[15]}}, center_x};
         oy_w = {{(SW - 16){center_y[15]}}, center_y} - {q2_cv_ff[RW-1], q2_cv_ff};
      end else begin
         ox_w = {q2_sv_ff[RW-1], q2_sv_ff};
         oy_w = {q2_cv_ff[RW-1], q2_cv_ff};
      end
      ox_c = clip16(ox_w);
      oy_c = clip16(oy_w);
      if (is_to_polar(q2_side_ff.mode)) begin
         rsp_in.angle_out  = q2_ang_ff;
         rsp_in.radius_out = q2_rad_ff;
         rsp_in.out_x      = '0;
         rsp_in.out_y      = '0;
         rsp_in.saturated  = q2_flag_ff;
      end else begin
         rsp_in.angle_out  = '0;
         rsp_in.radius_out = '0;
         rsp_in.out_x      = ox_c[15:0];
         rsp_in.out_y      = oy_c[15:0];
         rsp_in.saturated  = ox_c[16] | oy_c[16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (e1) begin
            v1_ff <= in_valid;
         end
         if (e2) begin
            v2_ff <= v1_ff;
         end
         if (e3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e1) begin
         q1_p_ff    <= q1_p_in;
         q1_x_ff    <= q1_x_in;
         q1_y_ff    <= q1_y_in;
         q1_z_ff    <= z_i[ANGLE_BITS-1:0];
         q1_side_ff <= side_i;
      end
      if (e2) begin
         q2_ang_ff  <= q2_ang_in;
         q2_rad_ff  <= q2_rad_in;
         q2_flag_ff <= q2_flag_in;
         q2_cv_ff   <= xr[CW-1:GUARD_BITS];
         q2_sv_ff   <= yr[CW-1:GUARD_BITS];
         q2_side_ff <= q1_side_ff;
      end
      if (e3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### sv/screen_polar_coordinate_converter_top.sv
// Top level of the radar-display coordinate converter: configuration registers and
// the front end, CORDIC and back end pipeline. Depends on spcc_pkg and the spcc_* modules.
`default_nettype none

// Converts one request per clock between screen, Cartesian and polar (bearing/range)
// coordinates. Coordinates are signed Q12.4, ranges unsigned Q12.4, bearings 16-bit
// binary angles (a full turn is 65536). Screen points are taken relative to the
// configured center with y pointing up; bearings are measured from north_offset,
// turning clockwise. Results that do not fit are clipped and flag saturated; fields
// that a mode does not produce read as zero. A request is accepted on any cycle in
// which some pipeline stage is free, so with rsp_ready held high the block takes one
// request per clock. Each request passes through two front-end stages (offset/fold with
// radius prescale multiply, prescale rounding), one register per CORDIC iteration, two
// back-end stages (gain multiply, rounding) and the output register. A stalled response
// holds in the output register while earlier stages keep filling bubbles. Write the csr_
// registers only while no request is in flight.
module screen_polar_coordinate_converter_top
   import spcc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT,
   parameter int ANGLE_BITS    = ANGLE_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire spcc_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output spcc_rsp_type      rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   localparam int AW = ANGLE_BITS + 1;

   logic signed [15:0]   center_x_ff, center_y_ff;
   logic [15:0]          north_offset_ff;

   logic                 pre_valid, pre_ready;
   logic signed [CW-1:0] pre_x, pre_y;
   logic [AW-1:0]        pre_z;
   spcc_side_type        pre_side;

   logic                 cor_valid, cor_ready;
   logic signed [CW-1:0] cor_x, cor_y;
   logic [AW-1:0]        cor_z;
   spcc_side_type        cor_side;

   // configuration registers; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         north_offset_ff <= NORTH_OFFSET_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CENTER_X: begin
               center_x_ff <= csr_wdata;
            end
            CSR_CENTER_Y: begin
               center_y_ff <= csr_wdata;
            end
            CSR_NORTH_OFFSET: begin
               north_offset_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // front end: screen offset, fold into the right half-plane, radius prescale
   spcc_pre #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .out_valid (pre_valid),
      .out_ready (pre_ready),
      .x_o       (pre_x),
      .y_o       (pre_y),
      .z_o       (pre_z),
      .side_o    (pre_side)
   );

   // shared CORDIC: vectoring for the modes to polar, rotation for the others
   spcc_cordic #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .ANGLE_BITS    (ANGLE_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_ready  (pre_ready),
      .x_i       (pre_x),
      .y_i       (pre_y),
      .z_i       (pre_z),
      .side_i    (pre_side),
      .out_valid (cor_valid),
      .out_ready (cor_ready),
      .x_o       (cor_x),
      .y_o       (cor_y),
      .z_o       (cor_z),
      .side_o    (cor_side)
   );

   // back end: gain removal, rounding, bearing offset, center add, clipping
   spcc_post #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_post (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (cor_valid),
      .in_ready     (cor_ready),
      .x_i          (cor_x),
      .y_i          (cor_y),
      .z_i          (cor_z),
      .side_i       (cor_side),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .north_offset (north_offset_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

### sv/spcc_checker.sv
// Port-level checker for the coordinate converter, bound to the top level.
// Depends on spcc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spcc_checker
   import spcc_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire spcc_rsp_type rsp_data
);

   logic rsp_stall;
   logic polar_zero;
   logic coord_zero;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign polar_zero = (rsp_data.angle_out == '0) && (rsp_data.radius_out == '0);
   assign coord_zero = (rsp_data.out_x == '0) && (rsp_data.out_y == '0);

   // a waiting response holds until taken
   `SPCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // reset empties the pipeline
   `SPCC_ASSERT_IMPLY(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

   // a free or draining output stage lets a request in
   `SPCC_ASSERT_IMPLY(a_ready_free, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // a response carries either polar fields or coordinate fields, never both
   `SPCC_ASSERT_IMPLY(a_one_form, clock, reset, rsp_valid, coord_zero || polar_zero)

endmodule

bind screen_polar_coordinate_converter_top spcc_checker u_spcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
